[src/lcu_pkg.sv]
package lcu_pkg;

  localparam int HIDDEN_MAX      = 1024;
  localparam int ACT_TABLE_DEPTH = 256;
  localparam int ADDR_W          = $clog2(HIDDEN_MAX);
  localparam int IDX_W           = 10;
  localparam int CFG_W           = 11;
  localparam int DATA_W          = 16;
  localparam int SUM_W           = 17;
  localparam int HID_W           = 14;
  localparam int ACT_W           = 14;
  localparam int TAB_W           = 13;
  localparam int KW              = $clog2(ACT_TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH     = 4;
  localparam int RESULT_DEPTH    = 4;
  localparam int ONE_Q12         = 4096;
  localparam int ROUND_Q12       = 2048;
  localparam int FRAC_W          = 12;

  // Series argument 16/DEPTH in Q30.
  localparam logic [63:0] EXP_STEP = (64'd1 << 34) / 64'(ACT_TABLE_DEPTH);

  typedef logic [TAB_W-1:0] tab_t [0:ACT_TABLE_DEPTH];

  // Work item handed from the front to the back.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    err;
    logic signed [ACT_W-1:0] ig;
    logic signed [ACT_W-1:0] fg;
    logic signed [ACT_W-1:0] gg;
    logic signed [ACT_W-1:0] og;
  } work_t;

  // Result word as it waits for the consumer.
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] cell_q12;
    logic signed [HID_W-1:0]  hidden;
    logic                     err;
  } res_t;

  // Shift-and-subtract quotient, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8k/DEPTH) in Q12, built from an integer exp series.
  function automatic tab_t build_tanh();
    logic [63:0] one, y, term, pos, neg, b, p, dv, den, num;
    tab_t t;
    one  = 64'd1 << 30;
    y    = EXP_STEP;
    term = one;
    pos  = one;
    neg  = '0;
    p    = one;
    for (int n = 1; n <= 24; n++) begin
      dv   = 64'(n) << 30;
      term = udiv64(term * y + (dv >> 1), dv);
      if (n[0]) neg = neg + term;
      else      pos = pos + term;
    end
    b = (pos > neg) ? pos - neg : 64'd0;
    if (b > one) b = one;
    for (int k = 0; k <= ACT_TABLE_DEPTH; k++) begin
      den  = one + p;
      num  = (one - p) << 12;
      t[k] = TAB_W'(udiv64(num + (den >> 1), den));
      p    = (p * b + (one >> 1)) >> 30;
    end
    return t;
  endfunction

  localparam tab_t TANH_TAB = build_tanh();

  // Table tanh of a Q12 value; half selects tanh(v/2).
  function automatic logic signed [ACT_W-1:0] act_tanh(logic signed [SUM_W-1:0] v,
                                                       logic half);
    logic [SUM_W:0]  m;
    logic [31:0]     k;
    logic [TAB_W-1:0] t;
    m = v[SUM_W-1] ? (SUM_W+1)'(-$signed({v[SUM_W-1], v})) : {1'b0, v};
    if (half) k = (32'(m) * 32'(ACT_TABLE_DEPTH) + 32'd32768) >> 16;
    else      k = (32'(m) * 32'(ACT_TABLE_DEPTH) + 32'd16384) >> 15;
    if (k > 32'(ACT_TABLE_DEPTH)) k = 32'(ACT_TABLE_DEPTH);
    t = TANH_TAB[KW'(k)];
    return v[SUM_W-1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
  endfunction

  function automatic logic signed [ACT_W-1:0] act_sigmoid(logic signed [SUM_W-1:0] v);
    logic signed [ACT_W+1:0] s;
    s = (ACT_W+2)'(ONE_Q12 + 1) + (ACT_W+2)'(act_tanh(v, 1'b1));
    return ACT_W'(s >>> 1);
  endfunction

endpackage

[src/lcu_queue.sv]
module lcu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcu_pkg::work_t word_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lcu_pkg::work_t word_out
);
  import lcu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W:0]   cnt;

  assign full     = (cnt == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (cnt != '0);
  assign word_out = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= word_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (pop && valid)  rp <= rp + 1'b1;
      cnt <= cnt + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && valid);
    end
  end

endmodule

[src/lcu_front.sv]
module lcu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          block,
  input  logic [lcu_pkg::CFG_W-1:0]     hidden_size,
  input  logic                          push,
  output logic                          full,
  input  logic [lcu_pkg::IDX_W-1:0]     unit_index,
  input  logic signed [lcu_pkg::DATA_W-1:0] in_gate_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] in_gate_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] forget_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] forget_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] cand_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] cand_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] out_gate_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] out_gate_r,
  output logic                          q_push,
  output lcu_pkg::work_t                q_word,
  input  logic                          q_full
);
  import lcu_pkg::*;

  logic                    valid;
  logic [IDX_W-1:0]        idx;
  logic                    err;
  logic signed [SUM_W-1:0] s_i, s_f, s_g, s_o;
  logic                    adv, accept;

  assign adv    = valid && !q_full;
  assign full   = block || (valid && q_full);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (accept) valid <= 1'b1;
    else if (adv) valid <= 1'b0;
  end

  // Add each pair exactly and classify the index.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= unit_index;
      err <= (32'(unit_index) >= 32'(hidden_size)) ||
             (32'(unit_index) >= 32'(HIDDEN_MAX));
      s_i <= SUM_W'(in_gate_x) + SUM_W'(in_gate_r);
      s_f <= SUM_W'(forget_x) + SUM_W'(forget_r);
      s_g <= SUM_W'(cand_x) + SUM_W'(cand_r);
      s_o <= SUM_W'(out_gate_x) + SUM_W'(out_gate_r);
    end
  end

  assign q_push = adv;

  always_comb begin
    q_word.idx = idx;
    q_word.err = err;
    q_word.ig  = act_sigmoid(s_i);
    q_word.fg  = act_sigmoid(s_f);
    q_word.gg  = act_tanh(s_g, 1'b0);
    q_word.og  = act_sigmoid(s_o);
  end

endmodule

[src/lcu_back.sv]
module lcu_back (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  clearing,
  input  logic                  q_valid,
  input  lcu_pkg::work_t        q_word,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output lcu_pkg::res_t         head
);
  import lcu_pkg::*;

  localparam int RPTR_W = $clog2(RESULT_DEPTH);
  localparam int PF_W   = ACT_W + DATA_W;

  logic [DATA_W-1:0] ram [HIDDEN_MAX];
  logic [ADDR_W-1:0] clr_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // stage B: cell read back
  logic              b_valid;
  work_t             b_w;
  logic [DATA_W-1:0] rdata;
  logic              ovr;
  logic [DATA_W-1:0] ovr_val;
  logic signed [DATA_W-1:0] b_cell;
  logic              b_load, b_adv, b_free, haz;

  // stage C: products, cell write
  logic              c_valid, c_err;
  logic [IDX_W-1:0]  c_idx;
  logic signed [ACT_W-1:0] c_og;
  logic signed [PF_W-1:0]  p_f, p_i;
  logic signed [PF_W:0]    acc;
  logic signed [PF_W-FRAC_W:0] rnd;
  logic signed [DATA_W-1:0] c_cell;
  logic              c_adv, c_free;

  // stage D: new cell held for the tanh lookup
  logic              d_valid, d_err;
  logic [IDX_W-1:0]  d_idx;
  logic signed [ACT_W-1:0]  d_og;
  logic signed [DATA_W-1:0] d_cell;
  logic              d_adv, d_free;

  // stage E: hidden product
  logic              e_valid, e_err;
  logic [IDX_W-1:0]  e_idx;
  logic signed [ACT_W-1:0]  e_og, e_t;
  logic signed [DATA_W-1:0] e_cell;
  logic signed [2*ACT_W-1:0] e_prod;
  logic              e_adv, e_free;

  // result queue
  res_t              rq [RESULT_DEPTH];
  logic [RPTR_W-1:0] rwp, rrp;
  logic [RPTR_W:0]   rcnt;
  logic              rfull;
  res_t              e_res;

  assign wr_addr = clearing ? clr_addr : ADDR_W'(c_idx);
  assign wr_data = clearing ? '0 : DATA_W'(c_cell);
  assign wr_en   = clearing || (c_adv && !c_err);

  always_ff @(posedge clk) begin
    if (wr_en) ram[wr_addr] <= wr_data;
    if (b_load) rdata <= ram[ADDR_W'(q_word.idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(HIDDEN_MAX - 1)) clearing <= 1'b0;
    end
  end

  // Stall B behind C on the same unit until the write has landed.
  assign haz    = c_valid && !c_err && (c_idx == b_w.idx);
  assign b_adv  = b_valid && c_free && !haz;
  assign b_free = !b_valid || b_adv;
  assign b_load = q_valid && b_free;
  assign q_pop  = b_load;
  assign b_cell = ovr ? $signed(ovr_val) : $signed(rdata);

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (b_load) b_valid <= 1'b1;
    else if (b_adv) b_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_w     <= q_word;
      ovr     <= wr_en && (wr_addr == ADDR_W'(q_word.idx));
      ovr_val <= wr_data;
    end else if (wr_en && (wr_addr == ADDR_W'(b_w.idx))) begin
      ovr     <= 1'b1;
      ovr_val <= wr_data;
    end
  end

  assign acc    = (PF_W+1)'(p_f) + (PF_W+1)'(p_i);
  assign rnd    = (PF_W-FRAC_W+1)'((acc + (PF_W+1)'(ROUND_Q12)) >>> FRAC_W);
  always_comb begin
    if (rnd > (PF_W-FRAC_W+1)'(32767))       c_cell = 16'sh7fff;
    else if (rnd < -(PF_W-FRAC_W+1)'(32768)) c_cell = -16'sh8000;
    else                                     c_cell = DATA_W'(rnd);
  end

  assign c_adv  = c_valid && d_free;
  assign c_free = !c_valid || c_adv;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (b_adv) c_valid <= 1'b1;
    else if (c_adv) c_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_idx <= b_w.idx;
      c_err <= b_w.err;
      c_og  <= b_w.og;
      p_f   <= PF_W'(b_w.fg * b_cell);
      p_i   <= PF_W'(b_w.ig * b_w.gg);
    end
  end

  assign d_adv  = d_valid && e_free;
  assign d_free = !d_valid || d_adv;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (c_adv) d_valid <= 1'b1;
    else if (d_adv) d_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      d_idx  <= c_idx;
      d_err  <= c_err;
      d_og   <= c_og;
      d_cell <= c_cell;
    end
  end

  assign rfull  = (rcnt == (RPTR_W+1)'(RESULT_DEPTH));
  assign e_adv  = e_valid && !rfull;
  assign e_free = !e_valid || e_adv;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (d_adv) e_valid <= 1'b1;
    else if (e_adv) e_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (d_adv) begin
      e_idx  <= d_idx;
      e_err  <= d_err;
      e_og   <= d_og;
      e_cell <= d_cell;
      e_t    <= act_tanh(SUM_W'(d_cell), 1'b0);
    end
  end

  assign e_prod = e_og * e_t;

  always_comb begin
    e_res.idx      = e_idx;
    e_res.err      = e_err;
    e_res.cell_q12 = e_err ? '0 : e_cell;
    e_res.hidden   = e_err ? '0 :
                     HID_W'((e_prod + (2*ACT_W)'(ROUND_Q12)) >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (e_adv) rq[rwp] <= e_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwp  <= '0;
      rrp  <= '0;
      rcnt <= '0;
    end else begin
      if (e_adv)          rwp <= rwp + 1'b1;
      if (pop && !empty)  rrp <= rrp + 1'b1;
      rcnt <= rcnt + (RPTR_W+1)'(e_adv) - (RPTR_W+1)'(pop && !empty);
    end
  end

  assign empty = (rcnt == '0);
  assign head  = rq[rrp];

endmodule

[src/lstm_cell_update.sv]
// LSTM elementwise cell update. Push one word per hidden unit: its index and
// the eight Q4.12 pre-activations. Each word yields one result word holding
// the index, the saturated new cell value and the hidden value; an index not
// below hidden_size flags index_error, returns zeros and leaves the cell
// store untouched. Both sides behave as queues (push/full in, empty/pop out).
// One word is accepted per clock while full is low. Two words for the same unit
// in adjacent slots stall, since the cell store's read-modify-write loop must
// close first. After reset the cell store is cleared to zero, one entry per
// cycle, and full stays high while it runs; hidden_size writes are taken at
// any time but belong in idle periods.
module lstm_cell_update (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              hidden_size_we,
  input  logic [lcu_pkg::CFG_W-1:0]         hidden_size_wdata,
  input  logic                              push,
  output logic                              full,
  input  logic [lcu_pkg::IDX_W-1:0]         unit_index,
  input  logic signed [lcu_pkg::DATA_W-1:0] in_gate_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] in_gate_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] forget_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] forget_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] cand_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] cand_r,
  input  logic signed [lcu_pkg::DATA_W-1:0] out_gate_x,
  input  logic signed [lcu_pkg::DATA_W-1:0] out_gate_r,
  output logic                              empty,
  input  logic                              pop,
  output logic [lcu_pkg::IDX_W-1:0]         result_index,
  output logic signed [lcu_pkg::DATA_W-1:0] new_cell,
  output logic signed [lcu_pkg::HID_W-1:0]  hidden_out,
  output logic                              index_error
);
  import lcu_pkg::*;

  logic [CFG_W-1:0] hidden_size;
  logic             clearing;
  logic             q_push, q_full, q_pop, q_valid;
  work_t            q_in, q_out;
  res_t             head;

  // Hold the unit count; reset enables every unit.
  always_ff @(posedge clk) begin
    if (rst) hidden_size <= CFG_W'(HIDDEN_MAX);
    else if (hidden_size_we) hidden_size <= hidden_size_wdata;
  end

  // Front: add the pairs, flag bad indices, look up the activations.
  lcu_front u_front (
    .clk, .rst,
    .block       (clearing),
    .hidden_size,
    .push, .full,
    .unit_index,
    .in_gate_x, .in_gate_r, .forget_x, .forget_r,
    .cand_x, .cand_r, .out_gate_x, .out_gate_r,
    .q_push, .q_word (q_in), .q_full
  );

  // Short queue so front and back stall on their own.
  lcu_queue u_queue (
    .clk, .rst,
    .push     (q_push),
    .word_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .word_out (q_out)
  );

  // Back: cell read-modify-write, hidden product, result queue.
  lcu_back u_back (
    .clk, .rst,
    .clearing,
    .q_valid, .q_word (q_out), .q_pop,
    .empty, .pop, .head
  );

  assign result_index = head.idx;
  assign new_cell     = head.cell_q12;
  assign hidden_out   = head.hidden;
  assign index_error  = head.err;

endmodule

[src/lcu_checker.sv]
module lcu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [lcu_pkg::IDX_W-1:0]         result_index,
  input logic signed [lcu_pkg::DATA_W-1:0] new_cell,
  input logic signed [lcu_pkg::HID_W-1:0]  hidden_out,
  input logic                              index_error
);
  import lcu_pkg::*;

  // The store clear keeps the input closed right after reset.
  a_clear_full: assert property (@(posedge clk) rst |=> full && empty)
    else $error("input open or result pending right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      (!empty && index_error) |-> (new_cell == '0 && hidden_out == '0))
    else $error("rejected word carries nonzero values");

  a_hid_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (hidden_out <= 14'sd4096 && hidden_out >= -14'sd4096))
    else $error("hidden value out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(result_index) && $stable(new_cell)))
    else $error("waiting result changed");

endmodule

bind lstm_cell_update lcu_checker u_checker (
  .clk, .rst, .full, .empty, .pop,
  .result_index, .new_cell, .hidden_out, .index_error
);
